[rtl/dqvs_pkg.sv]
`timescale 1ns / 1ps

package dqvs_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Word field widths
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;

    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN
    } state_t;

    // Ring index a + b, with a, b below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IDX_W-1:0];
    endfunction

    // Ring index a - 1
    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0)
        begin
            r = LAST_IDX;
        end
        else
        begin
            r = a - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

[rtl/dqvs_if.sv]
`timescale 1ns / 1ps

// Command channel
interface dqvs_req_if;
    import dqvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// Result channel
interface dqvs_rsp_if;
    import dqvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] popped_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         entry_count;

    modport source (output valid, output status, output popped_value,
                    output found_position, output entry_count, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input found_position, input entry_count, output ready);
endinterface

[rtl/deque_with_value_search_top.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue of 32-bit words in a ring of DEPTH entries.
// request carries a command and a value: push back, push front, pop front,
// find first equal entry, or clear. response returns one word per command:
// status, popped value, 1-based found position and the count afterwards.
// Path from acceptance to a valid response word:
//   push, clear, unused codes, full/empty rejects: the response register
//   pop: one registered read of the entry store, then the response register
//   find: one entry compared per cycle while the response register is free
// Throughput is one command at a time; the single read port of the entry
// store, walked by the scan counter, sets the find time.
// request.ready is high only while the sequencer is idle and the response
// register is empty or being taken. If the receiver stalls, the response
// word holds and the next command waits in the sender.
// Reset empties the queue (front and count to zero); store contents are
// left as they are and are never read before being written.
module deque_with_value_search_top (
    input  logic            clk,
    input  logic            rst_n,
    dqvs_req_if.sink        request,
    dqvs_rsp_if.source      response
);
    import dqvs_pkg::*;

    // Entry store
    logic [DATA_W-1:0] mem [DEPTH];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  rd_data_reg;

    logic               ovalid_reg;
    status_t            status_reg;
    logic [DATA_W-1:0]  popped_reg;
    logic [POS_W-1:0]   found_reg;
    logic [POS_W-1:0]   count_reg;

    logic               accept, out_free, is_full, is_empty, match, last;
    logic [CNT_W-1:0]   idx_plus;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic               wr_en;
    logic               res_load;
    status_t            res_status;
    logic [DATA_W-1:0]  res_popped;
    logic [POS_W-1:0]   res_found;

    // Handshake and flags
    assign out_free      = !ovalid_reg || response.ready;
    assign request.ready = (state_reg == S_IDLE) && out_free;
    assign accept        = request.valid && request.ready;
    assign is_full       = (occ_reg == DEPTH_C);
    assign is_empty      = (occ_reg == '0);
    assign match         = (rd_data_reg == val_reg);
    assign idx_plus      = CNT_W'(idx_reg) + CNT_W'(1);
    assign last          = (idx_plus == occ_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_empty && request.command == CMD_POP_FRONT)
                begin
                    state_next = S_POP;
                end
                else if (accept && !is_empty && request.command == CMD_FIND)
                begin
                    state_next = S_SCAN;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (out_free && (match || last))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result
    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        val_next   = val_reg;
        rd_addr    = cur_reg;
        wr_addr    = front_reg;
        wr_en      = 1'b0;
        res_load   = 1'b0;
        res_status = ST_OK;
        res_popped = '0;
        res_found  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = front_reg;
                if (accept)
                begin
                    val_next = request.value;
                    cur_next = front_reg;
                    idx_next = '0;
                    unique case (request.command)
                        CMD_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = ring_add(front_reg, occ_reg[IDX_W-1:0]);
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_FRONT:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_dec(front_reg);
                                front_next = ring_dec(front_reg);
                                occ_next   = occ_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (is_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = ST_MISSING;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            res_load   = 1'b1;
                            front_next = '0;
                            occ_next   = '0;
                        end
                        default: res_load = 1'b1;
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_popped = rd_data_reg;
                    front_next = ring_add(front_reg, IDX_W'(1));
                    occ_next   = occ_reg - CNT_W'(1);
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    if (match)
                    begin
                        res_load  = 1'b1;
                        res_found = POS_W'(idx_plus);
                    end
                    else if (last)
                    begin
                        res_load   = 1'b1;
                        res_status = ST_MISSING;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        cur_next = ring_add(cur_reg, IDX_W'(1));
                        rd_addr  = ring_add(cur_reg, IDX_W'(1));
                    end
                end
            end
            default: rd_addr = cur_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
            if (res_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        val_reg <= val_next;
        if (res_load)
        begin
            status_reg <= res_status;
            popped_reg <= res_popped;
            found_reg  <= res_found;
            count_reg  <= POS_W'(occ_next);
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_next;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Response port
    assign response.valid          = ovalid_reg;
    assign response.status         = status_reg;
    assign response.popped_value   = popped_reg;
    assign response.found_position = found_reg;
    assign response.entry_count    = count_reg;

endmodule

[tb/sv/deque_with_value_search_top_tb.sv]
`timescale 1ns / 1ps

module deque_with_value_search_top_tb;
    import dqvs_pkg::*;

    // One expected response word
    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] popped_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         entry_count;
    } deque_result_t;

    logic clk;
    logic rst_n;

    dqvs_req_if req_bus ();
    dqvs_rsp_if rsp_bus ();

    deque_with_value_search_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_bus),
        .response (rsp_bus)
    );

    // Mirror of the deque contents
    logic signed [DATA_W-1:0] mirror_store [DEPTH];
    int                       mirror_head;
    int                       mirror_count;

    deque_result_t pending_results [$];
    int            error_count;

    // Sender burst control
    int burst_left;
    bit sender_gaps_on;

    // Receiver stall control
    bit rx_steady;
    bit hold_request;
    int hold_left;
    int rx_seg_left;
    int rx_stall_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Apply one command to the mirror and return the word it must produce
    function automatic deque_result_t predict_deque_result(input logic [CMD_W-1:0] cmd,
                                                           input logic signed [DATA_W-1:0] val);
        deque_result_t res;
        int            i;
        res.status         = ST_OK;
        res.popped_value   = '0;
        res.found_position = '0;
        case (cmd)
            CMD_PUSH_BACK:
            begin
                if (mirror_count >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    mirror_store[(mirror_head + mirror_count) % DEPTH] = val;
                    mirror_count++;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (mirror_count >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                    mirror_store[mirror_head] = val;
                    mirror_count++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (mirror_count == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.popped_value = mirror_store[mirror_head];
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_count--;
                end
            end
            CMD_FIND:
            begin
                res.status = ST_MISSING;
                for (i = 0; i < mirror_count; i++)
                begin
                    if (res.status == ST_MISSING &&
                        mirror_store[(mirror_head + i) % DEPTH] == val)
                    begin
                        res.status         = ST_OK;
                        res.found_position = POS_W'(i + 1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                mirror_head  = 0;
                mirror_count = 0;
            end
            default:
            begin
            end
        endcase
        res.entry_count = POS_W'(mirror_count);
        return res;
    endfunction

    // Offer one command word, with random gaps between bursts
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_bus.valid   <= 1'b1;
        req_bus.command <= cmd;
        req_bus.value   <= val;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        pending_results.insert(pending_results.size(), predict_deque_result(cmd, val));
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Receiver: stall pattern, long hold-off on request, response checks
    initial
    begin
        deque_result_t exp_word;
        rsp_bus.ready <= 1'b0;
        rx_seg_left  = 0;
        rx_stall_pct = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected response word, status %0d count %0d",
                             $time, rsp_bus.status, rsp_bus.entry_count);
                    error_count++;
                end
                else
                begin
                    exp_word = pending_results[0];
                    pending_results.delete(0);
                    check_field("status", DATA_W'(exp_word.status), DATA_W'(rsp_bus.status));
                    check_field("popped_value", exp_word.popped_value, rsp_bus.popped_value);
                    check_field("found_position", DATA_W'(exp_word.found_position),
                                DATA_W'(rsp_bus.found_position));
                    check_field("entry_count", DATA_W'(exp_word.entry_count),
                                DATA_W'(rsp_bus.entry_count));
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (rx_seg_left == 0)
            begin
                rx_seg_left = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 25;
                    2: rx_stall_pct = 50;
                    default: rx_stall_pct = 85;
                endcase
            end
            rx_seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (rx_steady)
            begin
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Value mix: small pool for repeats, extremes, and full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = DATA_W'($urandom_range(0, 7));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = -32'sd1;
                    default: v = '0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Search key: usually an entry now held, so finds hit at every depth
    function automatic logic signed [DATA_W-1:0] pick_search_key();
        logic signed [DATA_W-1:0] v;
        if (mirror_count > 0 && $urandom_range(0, 99) < 60)
        begin
            v = mirror_store[(mirror_head + $urandom_range(0, mirror_count - 1)) % DEPTH];
        end
        else
        begin
            v = pick_value();
        end
        return v;
    endfunction

    // Boundaries: empty, full, extreme values, unused codes, clear
    task automatic test_directed_edges();
        int i;
        send_command(CMD_POP_FRONT, 32'sd5);
        send_command(CMD_FIND, 32'sd0);
        send_command(3'd5, 32'sh7FFF_FFFF);
        send_command(3'd6, 32'sh8000_0000);
        send_command(3'd7, -32'sd1);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(CMD_FIND, 32'sh8000_0000);
        send_command(CMD_FIND, 32'sd12345);
        for (i = 0; i < DEPTH - 2; i++)
        begin
            send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                         (i == DEPTH - 3) ? -32'sd1 : 32'(i * 32'h1111_1111));
        end
        send_command(CMD_PUSH_BACK, 32'sd1);
        send_command(CMD_PUSH_FRONT, 32'sd2);
        send_command(CMD_FIND, -32'sd1);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_POP_FRONT, 32'sd0);
    endtask

    // Random command stream with a given lean toward filling or draining
    task automatic test_random_traffic(input int num_items, input int push_pct,
                                       input int pop_pct);
        int                       n;
        int                       r;
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
        for (n = 0; n < num_items; n++)
        begin
            r   = $urandom_range(0, 99);
            val = pick_value();
            if (r < push_pct)
            begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end
            else if (r < push_pct + pop_pct)
            begin
                cmd = CMD_POP_FRONT;
            end
            else if (r < push_pct + pop_pct + 20)
            begin
                cmd = CMD_FIND;
                val = pick_search_key();
            end
            else if (r < push_pct + pop_pct + 23)
            begin
                cmd = CMD_CLEAR;
            end
            else
            begin
                cmd = CMD_W'($urandom_range(5, 7));
            end
            send_command(cmd, val);
        end
    endtask

    // Back-to-back traffic with the receiver always ready
    task automatic test_full_rate();
        sender_gaps_on = 1'b0;
        rx_steady      = 1'b1;
        test_random_traffic(200, 40, 30);
        sender_gaps_on = 1'b1;
        rx_steady      = 1'b0;
    endtask

    // Receiver holds off while commands keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        test_random_traffic(60, 45, 25);
        hold_request = 1'b1;
        test_random_traffic(60, 20, 50);
    endtask

    // Stimulus sequence
    initial
    begin
        error_count    = 0;
        burst_left     = 0;
        sender_gaps_on = 1'b1;
        rx_steady      = 1'b0;
        hold_request   = 1'b0;
        mirror_head    = 0;
        mirror_count   = 0;
        rst_n           <= 1'b0;
        req_bus.valid   <= 1'b0;
        req_bus.command <= CMD_PUSH_BACK;
        req_bus.value   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic(700, 40, 30);
        test_random_traffic(350, 60, 12);
        test_random_traffic(350, 15, 55);
        test_full_rate();
        test_backpressure();
        test_random_traffic(200, 60, 12);

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 4) @(posedge clk);

        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[deque_with_value_search_top.f]
rtl/dqvs_pkg.sv
rtl/dqvs_if.sv
rtl/deque_with_value_search_top.sv
tb/sv/deque_with_value_search_top_tb.sv
